>>> hw/rtl/gbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbe_pkg: shared definitions for the grid block extent calculator
// Field widths, register indexes and the status record of the serial units.
// ----------------------------------------------------------------------------
package gbe_pkg;

    // fixed field widths
    localparam int IDX_W      = 12;  // block number and block index
    localparam int CNT_W      = 13;  // block count and blocks per axis
    localparam int CFG_IDX_W  = 8;   // configuration register index
    localparam int CFG_DATA_W = 32;  // configuration write data

    // defaults for the top level parameters
    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int SIZE_BITS_DEF  = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_X      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Y      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Z      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 8'd3;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;  // iterating
        logic done;  // one-cycle pulse, result valid from here on
    } unit_stat_t;

endpackage

>>> hw/rtl/gbe_serial_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbe_serial_div: restoring divider, one quotient bit per cycle
// The dividend shifts out of the quotient register MSB first while the
// quotient bits shift in; done pulses once the last quotient bit is in.
// ----------------------------------------------------------------------------
module gbe_serial_div #(
    parameter int DIVIDEND_W = 28,
    parameter int DIVISOR_W  = 13
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder,
    output gbe_pkg::unit_stat_t   stat
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // one trial subtraction
    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIVIDEND_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> hw/rtl/gbe_serial_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbe_serial_mul: shift-and-add multiplier, one multiplier bit per cycle
// The multiplier sits in the low end of the accumulator and shifts out LSB
// first; done pulses once the last multiplier bit has been used.
// ----------------------------------------------------------------------------
module gbe_serial_mul #(
    parameter int A_W = 12,
    parameter int B_W = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [A_W-1:0]       mul_a,
    input  logic [B_W-1:0]       mul_b,
    output logic [A_W+B_W-1:0]   product,
    output gbe_pkg::unit_stat_t  stat
);

    localparam int P_W    = A_W + B_W;
    localparam int STEP_W = $clog2(A_W + 1);

    logic [P_W-1:0]    acc_reg;
    logic [B_W-1:0]    b_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [B_W:0]      sum;

    // add the multiplicand into the upper B_W bits when the current bit is set
    assign sum = {1'b0, acc_reg[P_W-1:A_W]} + (acc_reg[0] ? {1'b0, b_reg} : '0);

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(A_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= {{B_W{1'b0}}, mul_a};
            b_reg   <= mul_b;
        end else if (busy_reg) begin
            acc_reg <= {sum, acc_reg[A_W-1:1]};
        end
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> hw/rtl/grid_block_extent_calculator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_block_extent_calculator_unit: block index, origin and extent per block
// Splits a 3D point grid into the configured number of blocks and answers,
// for each block number request, the block's 3D index, first point and size.
// ----------------------------------------------------------------------------
// One request is worked at a time, with a single shared bit-serial divider
// and a bit-serial multiplier: up to 12 factors of two are stripped, at most
// one division for the odd part, up to 12 halving steps, then per axis one
// division for the mixed-radix digit, one multiplication and one or two
// divisions for origin and end. A new request is taken while the previous
// result still waits in the output register. Configuration must be written
// by the user only while no request is in flight; the block itself does
// not enforce this, and cfg_ready is tied high.
// ----------------------------------------------------------------------------
module grid_block_extent_calculator_unit #(
    parameter int MAX_BLOCKS = gbe_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = gbe_pkg::SIZE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gbe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gbe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // request
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [gbe_pkg::IDX_W-1:0]         s_block_number,
    // result
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [gbe_pkg::IDX_W-1:0]         m_index_x,
    output logic [gbe_pkg::IDX_W-1:0]         m_index_y,
    output logic [gbe_pkg::IDX_W-1:0]         m_index_z,
    output logic [SIZE_BITS-1:0]              m_origin_x,
    output logic [SIZE_BITS-1:0]              m_origin_y,
    output logic [SIZE_BITS-1:0]              m_origin_z,
    output logic [SIZE_BITS-1:0]              m_extent_x,
    output logic [SIZE_BITS-1:0]              m_extent_y,
    output logic [SIZE_BITS-1:0]              m_extent_z
);

    localparam int IDX_W = gbe_pkg::IDX_W;
    localparam int CNT_W = gbe_pkg::CNT_W;
    localparam int P_W   = IDX_W + SIZE_BITS;
    localparam int EXP_W = $clog2(CNT_W);

    typedef logic [1:0] axis_t;
    localparam axis_t AX_X = 2'd0;
    localparam axis_t AX_Y = 2'd1;
    localparam axis_t AX_Z = 2'd2;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_STRIP    = 11'b000_0000_0010,
        ST_ODD_DIV  = 11'b000_0000_0100,
        ST_HALVE    = 11'b000_0000_1000,
        ST_AX_START = 11'b000_0001_0000,
        ST_AX_DIV   = 11'b000_0010_0000,
        ST_MUL      = 11'b000_0100_0000,
        ST_ORG_DIV  = 11'b000_1000_0000,
        ST_END_DIV  = 11'b001_0000_0000,
        ST_NEXT     = 11'b010_0000_0000,
        ST_DONE     = 11'b100_0000_0000
    } state_t;

    // pick one of three per-axis values
    function automatic logic [SIZE_BITS-1:0] pick_size(
        input logic [SIZE_BITS-1:0] v0,
        input logic [SIZE_BITS-1:0] v1,
        input logic [SIZE_BITS-1:0] v2,
        input axis_t                sel
    );
        logic [SIZE_BITS-1:0] r;
        case (sel)
            AX_X:    r = v0;
            AX_Y:    r = v1;
            default: r = v2;
        endcase
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] pick_cnt(
        input logic [CNT_W-1:0] v0,
        input logic [CNT_W-1:0] v1,
        input logic [CNT_W-1:0] v2,
        input axis_t            sel
    );
        logic [CNT_W-1:0] r;
        case (sel)
            AX_X:    r = v0;
            AX_Y:    r = v1;
            default: r = v2;
        endcase
        return r;
    endfunction

    // longest axis, ties to the lowest
    function automatic axis_t longest(
        input logic [SIZE_BITS-1:0] w0,
        input logic [SIZE_BITS-1:0] w1,
        input logic [SIZE_BITS-1:0] w2
    );
        axis_t                a;
        logic [SIZE_BITS-1:0] best;
        a    = AX_X;
        best = w0;
        if (w1 > best) begin
            a    = AX_Y;
            best = w1;
        end
        if (w2 > best) begin
            a = AX_Z;
        end
        return a;
    endfunction

    // configuration registers
    logic [SIZE_BITS-1:0] grid_x_reg, grid_y_reg, grid_z_reg;
    logic [CNT_W-1:0]     count_reg;

    // request working state
    state_t               state_reg, state_next;
    logic [SIZE_BITS-1:0] g_reg    [3];
    logic [SIZE_BITS-1:0] work_reg [3];
    logic [CNT_W-1:0]     per_reg  [3];
    logic [CNT_W-1:0]     odd_reg;
    logic [EXP_W-1:0]     exp_reg;
    logic [IDX_W-1:0]     num_reg;
    axis_t                axis_reg;
    axis_t                odd_axis_reg;
    logic [IDX_W-1:0]     digit_reg;
    logic [P_W-1:0]       prod_reg;
    logic [SIZE_BITS-1:0] org_reg;
    logic [SIZE_BITS-1:0] end_reg;
    logic [IDX_W-1:0]     res_idx_reg [3];
    logic [SIZE_BITS-1:0] res_org_reg [3];
    logic [SIZE_BITS-1:0] res_ext_reg [3];

    // output register
    logic                 m_valid_reg;
    logic [IDX_W-1:0]     out_idx_reg [3];
    logic [SIZE_BITS-1:0] out_org_reg [3];
    logic [SIZE_BITS-1:0] out_ext_reg [3];

    // serial units
    logic                 div_start;
    logic [P_W-1:0]       div_dividend;
    logic [CNT_W-1:0]     div_divisor;
    logic [P_W-1:0]       div_quo;
    logic [CNT_W-1:0]     div_rem;
    gbe_pkg::unit_stat_t  div_stat;
    logic                 mul_start;
    logic [P_W-1:0]       mul_prod;
    gbe_pkg::unit_stat_t  mul_stat;

    // derived values
    logic [CNT_W-1:0]     count_sat;
    axis_t                long_axis;
    logic [SIZE_BITS-1:0] long_work;
    logic [CNT_W-1:0]     cur_per;
    logic [SIZE_BITS-1:0] cur_span;
    logic                 last_block;
    logic                 out_free;

    assign count_sat = (count_reg == '0) ? CNT_W'(1) :
                       (32'(count_reg) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : count_reg;
    assign long_axis  = longest(work_reg[0], work_reg[1], work_reg[2]);
    assign long_work  = pick_size(work_reg[0], work_reg[1], work_reg[2], long_axis);
    assign cur_per    = pick_cnt(per_reg[0], per_reg[1], per_reg[2], axis_reg);
    assign cur_span   = pick_size(g_reg[0], g_reg[1], g_reg[2], axis_reg) - 1'b1;
    assign last_block = (({1'b0, digit_reg} + 1'b1) == cur_per);
    assign out_free   = !m_valid_reg || m_ready;

    // configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_x_reg <= SIZE_BITS'(1);
            grid_y_reg <= SIZE_BITS'(1);
            grid_z_reg <= SIZE_BITS'(1);
            count_reg  <= CNT_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                gbe_pkg::REG_GRID_X:      grid_x_reg <= cfg_wdata[SIZE_BITS-1:0];
                gbe_pkg::REG_GRID_Y:      grid_y_reg <= cfg_wdata[SIZE_BITS-1:0];
                gbe_pkg::REG_GRID_Z:      grid_z_reg <= cfg_wdata[SIZE_BITS-1:0];
                gbe_pkg::REG_BLOCK_COUNT: count_reg  <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer: next state and unit launches
    always_comb begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = cur_per;
        mul_start    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_STRIP;
            end
            ST_STRIP: begin
                if (odd_reg[0]) begin
                    if (odd_reg != CNT_W'(1)) begin
                        div_start    = 1'b1;
                        div_dividend = P_W'(long_work);
                        div_divisor  = odd_reg;
                        state_next   = ST_ODD_DIV;
                    end else begin
                        state_next = ST_HALVE;
                    end
                end
            end
            ST_ODD_DIV: begin
                if (div_stat.done) state_next = ST_HALVE;
            end
            ST_HALVE: begin
                if (exp_reg == '0) state_next = ST_AX_START;
            end
            ST_AX_START: begin
                div_start    = 1'b1;
                div_dividend = P_W'(num_reg);
                state_next   = ST_AX_DIV;
            end
            ST_AX_DIV: begin
                if (div_stat.done) begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_stat.done) begin
                    div_start    = 1'b1;
                    div_dividend = mul_prod;
                    state_next   = ST_ORG_DIV;
                end
            end
            ST_ORG_DIV: begin
                if (div_stat.done) begin
                    if (last_block) begin
                        state_next = ST_NEXT;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = prod_reg + P_W'(cur_span);
                        state_next   = ST_END_DIV;
                    end
                end
            end
            ST_END_DIV: begin
                if (div_stat.done) state_next = ST_NEXT;
            end
            ST_NEXT: begin
                state_next = (axis_reg == AX_Z) ? ST_DONE : ST_AX_START;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // request datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                g_reg[0]    <= (grid_x_reg == '0) ? SIZE_BITS'(1) : grid_x_reg;
                g_reg[1]    <= (grid_y_reg == '0) ? SIZE_BITS'(1) : grid_y_reg;
                g_reg[2]    <= (grid_z_reg == '0) ? SIZE_BITS'(1) : grid_z_reg;
                work_reg[0] <= (grid_x_reg == '0) ? SIZE_BITS'(1) : grid_x_reg;
                work_reg[1] <= (grid_y_reg == '0) ? SIZE_BITS'(1) : grid_y_reg;
                work_reg[2] <= (grid_z_reg == '0) ? SIZE_BITS'(1) : grid_z_reg;
                per_reg[0]  <= CNT_W'(1);
                per_reg[1]  <= CNT_W'(1);
                per_reg[2]  <= CNT_W'(1);
                odd_reg     <= count_sat;
                exp_reg     <= '0;
                num_reg     <= s_block_number;
                axis_reg    <= AX_X;
            end
            ST_STRIP: begin
                // strip one factor of two per cycle
                if (!odd_reg[0]) begin
                    odd_reg <= {1'b0, odd_reg[CNT_W-1:1]};
                    exp_reg <= exp_reg + 1'b1;
                end else if (odd_reg != CNT_W'(1)) begin
                    per_reg[long_axis] <= odd_reg;
                    odd_axis_reg       <= long_axis;
                end
            end
            ST_ODD_DIV: begin
                if (div_stat.done) work_reg[odd_axis_reg] <= div_quo[SIZE_BITS-1:0];
            end
            ST_HALVE: begin
                // one factor of two to the longest working axis
                if (exp_reg != '0) begin
                    per_reg[long_axis]  <= {per_reg[long_axis][CNT_W-2:0], 1'b0};
                    work_reg[long_axis] <= {1'b0, long_work[SIZE_BITS-1:1]};
                    exp_reg             <= exp_reg - 1'b1;
                end
            end
            ST_AX_DIV: begin
                if (div_stat.done) begin
                    digit_reg <= div_rem[IDX_W-1:0];
                    num_reg   <= div_quo[IDX_W-1:0];
                end
            end
            ST_MUL: begin
                if (mul_stat.done) prod_reg <= mul_prod;
            end
            ST_ORG_DIV: begin
                if (div_stat.done) begin
                    org_reg <= div_quo[SIZE_BITS-1:0];
                    if (last_block) end_reg <= cur_span;
                end
            end
            ST_END_DIV: begin
                if (div_stat.done) end_reg <= div_quo[SIZE_BITS-1:0];
            end
            ST_NEXT: begin
                res_idx_reg[axis_reg] <= digit_reg;
                res_org_reg[axis_reg] <= org_reg;
                res_ext_reg[axis_reg] <= end_reg - org_reg + 1'b1;
                axis_reg              <= axis_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            out_idx_reg <= res_idx_reg;
            out_org_reg <= res_org_reg;
            out_ext_reg <= res_ext_reg;
        end
    end

    // serial units
    gbe_serial_div #(
        .DIVIDEND_W (P_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    gbe_serial_mul #(
        .A_W (IDX_W),
        .B_W (SIZE_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mul_a   (div_rem[IDX_W-1:0]),
        .mul_b   (cur_span),
        .product (mul_prod),
        .stat    (mul_stat)
    );

    // ports
    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_index_x  = out_idx_reg[0];
    assign m_index_y  = out_idx_reg[1];
    assign m_index_z  = out_idx_reg[2];
    assign m_origin_x = out_org_reg[0];
    assign m_origin_y = out_org_reg[1];
    assign m_origin_z = out_org_reg[2];
    assign m_extent_x = out_ext_reg[0];
    assign m_extent_y = out_ext_reg[1];
    assign m_extent_z = out_ext_reg[2];

    // checks
    a_div_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider launched while busy");

    a_mul_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier launched while busy");

    a_split_product: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_AX_START && axis_reg == AX_X) |->
        (39'(per_reg[0]) * 39'(per_reg[1]) * 39'(per_reg[2]) == 39'(count_sat)))
        else $error("blocks per axis do not multiply to the block count");

    a_origin_le_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NEXT) |-> (org_reg <= end_reg))
        else $error("block origin beyond block end");

    a_request_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_STRIP && !s_ready))
        else $error("accepted request did not start");

endmodule

>>> dv/tb_grid_block_extent_calculator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_block_extent_calculator_unit: self-checking bench for the block
// extent calculator
// Writes grid sizes and block counts over the configuration port and sends
// block number requests. A local model of the block splitting predicts each
// result, and a scoreboard compares every returned field in order. Both
// channels idle at random. One phase holds off the result side so that the
// input side stalls.
// ----------------------------------------------------------------------------
module tb_grid_block_extent_calculator_unit;

    localparam int IDX_W          = gbe_pkg::IDX_W;
    localparam int CNT_W          = gbe_pkg::CNT_W;
    localparam int CFG_IDX_W      = gbe_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W     = gbe_pkg::CFG_DATA_W;
    localparam int SZ             = gbe_pkg::SIZE_BITS_DEF;
    localparam int QUIET_LIMIT    = 20000;  // cycles with no handshake at all
    localparam int DRAIN_WAIT     = 400;    // above the worst request latency

    typedef struct packed {
        logic [IDX_W-1:0]         block_no;
        logic [2:0][IDX_W-1:0]    index;
        logic [2:0][SZ-1:0]       origin;
        logic [2:0][SZ-1:0]       extent;
    } block_extent_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [IDX_W-1:0]       s_block_number;
    logic                   m_valid;
    logic                   m_ready;
    logic [IDX_W-1:0]       m_index_x, m_index_y, m_index_z;
    logic [SZ-1:0]          m_origin_x, m_origin_y, m_origin_z;
    logic [SZ-1:0]          m_extent_x, m_extent_y, m_extent_z;

    // shadow of the configuration registers
    logic [SZ-1:0]          grid_pts [3];
    logic [CNT_W-1:0]       blocks_cfg;

    block_extent_t          pending_extents [$];
    int                     mismatch_count;
    int                     quiet_cycles;
    bit                     idling_on;
    int                     receiver_hold;
    int                     stall_left;
    string                  axis_tag [3] = '{"x", "y", "z"};

    grid_block_extent_calculator_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_block_number (s_block_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_index_x      (m_index_x),
        .m_index_y      (m_index_y),
        .m_index_z      (m_index_z),
        .m_origin_x     (m_origin_x),
        .m_origin_y     (m_origin_y),
        .m_origin_z     (m_origin_z),
        .m_extent_x     (m_extent_x),
        .m_extent_y     (m_extent_y),
        .m_extent_z     (m_extent_z)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Block splitting model
    // ------------------------------------------------------------------------
    function automatic int longest_axis(input longint unsigned w [3]);
        int a;
        a = 0;
        if (w[1] > w[a]) a = 1;
        if (w[2] > w[a]) a = 2;
        return a;
    endfunction

    function automatic longint unsigned effective_blocks();
        longint unsigned n;
        n = (blocks_cfg == 0) ? 1 : blocks_cfg;
        if (n > gbe_pkg::MAX_BLOCKS_DEF) n = gbe_pkg::MAX_BLOCKS_DEF;
        return n;
    endfunction

    function automatic block_extent_t predict_extent(input logic [IDX_W-1:0] block_no);
        longint unsigned g [3];
        longint unsigned work [3];
        longint unsigned per [3];
        longint unsigned odd, twos, num, b, i, span, org, last_pt;
        int a;
        block_extent_t r;
        for (int d = 0; d < 3; d++) begin
            g[d]    = (grid_pts[d] == 0) ? 1 : grid_pts[d];
            work[d] = g[d];
            per[d]  = 1;
        end
        // odd part first, then one halving per factor of two
        odd  = effective_blocks();
        twos = 1;
        while (odd % 2 == 0) begin
            odd  = odd / 2;
            twos = twos * 2;
        end
        if (odd > 1) begin
            a       = longest_axis(work);
            per[a]  = odd;
            work[a] = work[a] / odd;
        end
        while (twos > 1) begin
            a       = longest_axis(work);
            per[a]  = per[a] * 2;
            work[a] = work[a] / 2;
            twos    = twos / 2;
        end
        // mixed-radix digits, x fastest
        r.block_no = block_no;
        num = block_no;
        for (int d = 0; d < 3; d++) begin
            b       = per[d];
            i       = num % b;
            span    = g[d] - 1;
            org     = (i * span) / b;
            last_pt = (i + 1 < b) ? ((i + 1) * span) / b : span;
            num     = num / b;
            r.index[d]  = IDX_W'(i);
            r.origin[d] = SZ'(org);
            r.extent[d] = SZ'(last_pt - org + 1);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
        $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : check_results
        block_extent_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got.block_no = '0;
            got.index    = {m_index_z, m_index_y, m_index_x};
            got.origin   = {m_origin_z, m_origin_y, m_origin_x};
            got.extent   = {m_extent_z, m_extent_y, m_extent_x};
            if (pending_extents.size() == 0) begin
                flag_mismatch("result with no request outstanding", 0, 1);
            end else begin
                want = pending_extents.pop_front();
                for (int d = 0; d < 3; d++) begin
                    if (got.index[d] !== want.index[d])
                        flag_mismatch($sformatf("block %0d index_%s", want.block_no,
                                      axis_tag[d]), want.index[d], got.index[d]);
                    if (got.origin[d] !== want.origin[d])
                        flag_mismatch($sformatf("block %0d origin_%s", want.block_no,
                                      axis_tag[d]), want.origin[d], got.origin[d]);
                    if (got.extent[d] !== want.extent[d])
                        flag_mismatch($sformatf("block %0d extent_%s", want.block_no,
                                      axis_tag[d]), want.extent[d], got.extent[d]);
                end
            end
        end
    end

    // stop a hung run: no handshake on any channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: long hold-off on request, otherwise random stall bursts while idling is on
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (receiver_hold > 0) begin
                m_ready <= 1'b0;
                receiver_hold--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(1, 18) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Channel tasks: each is entered just after a rising edge
    // ------------------------------------------------------------------------
    task automatic write_register(input logic [CFG_IDX_W-1:0] reg_idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= reg_idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (reg_idx)
            gbe_pkg::REG_GRID_X:      grid_pts[0] = data[SZ-1:0];
            gbe_pkg::REG_GRID_Y:      grid_pts[1] = data[SZ-1:0];
            gbe_pkg::REG_GRID_Z:      grid_pts[2] = data[SZ-1:0];
            gbe_pkg::REG_BLOCK_COUNT: blocks_cfg  = data[CNT_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_setting(input int gx, input int gy, input int gz, input int count);
        write_register(gbe_pkg::REG_GRID_X, gx);
        write_register(gbe_pkg::REG_GRID_Y, gy);
        write_register(gbe_pkg::REG_GRID_Z, gz);
        write_register(gbe_pkg::REG_BLOCK_COUNT, count);
    endtask

    // valid may stay high into the next request when no gap is drawn
    task automatic send_request(input logic [IDX_W-1:0] block_no);
        s_valid        <= 1'b1;
        s_block_number <= block_no;
        do @(posedge aclk); while (!s_ready);
        pending_extents.push_back(predict_extent(block_no));
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    // drop valid and wait until every expected result is back
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_extents.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [IDX_W-1:0] pick_block_no();
        if ($urandom_range(0, 4) == 0)
            return IDX_W'($urandom_range(0, 4095));
        return IDX_W'($urandom_range(0, effective_blocks() - 1));
    endfunction

    function automatic int pick_grid();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 1;
            2:       return 65535;
            3, 4:    return $urandom_range(0, 65535);
            default: return $urandom_range(2, 200);
        endcase
    endfunction

    function automatic int pick_count();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 1 << $urandom_range(0, 12);
            2:       return $urandom_range(4096, 8191);
            3:       return $urandom_range(0, 8191);
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // reset values: a single block covering a one-point grid
    task automatic test_reset_defaults();
        send_request(0);
        send_request(4095);
        settle();
    endtask

    task automatic test_directed_settings();
        // largest grid, most blocks: twelve halvings
        apply_setting(65535, 65535, 65535, 4096);
        send_request(0);
        send_request(4095);
        send_request(1234);
        settle();
        // count above the maximum saturates
        apply_setting(65535, 1, 1, 8191);
        send_request(0);
        send_request(4095);
        settle();
        // zero sizes read as one point, zero count as one block
        apply_setting(0, 0, 0, 0);
        send_request(0);
        send_request(4095);
        settle();
        // odd count on a tie goes to x; block number 3 wraps
        apply_setting(100, 100, 100, 3);
        for (int n = 0; n < 4; n++) send_request(n);
        settle();
        // large odd count on a long z axis, last block and wrap
        apply_setting(2, 3, 65535, 4095);
        send_request(0);
        send_request(4094);
        send_request(4095);
        settle();
        // mixed odd and even factors across unequal axes
        apply_setting(1, 65535, 0, 12);
        send_request(0);
        send_request(11);
        send_request(12);
        settle();
        // more blocks than points: working sizes fall to zero
        apply_setting(7, 7, 7, 4096);
        send_request(0);
        send_request(4095);
        settle();
    endtask

    // result side held off so the block fills and stalls its input
    task automatic test_output_stall();
        idling_on = 1'b0;
        apply_setting(pick_grid(), pick_grid(), pick_grid(), pick_count());
        receiver_hold = 1500;
        repeat (12) send_request(pick_block_no());
        settle();
    endtask

    task automatic test_random_settings();
        int sent;
        int phase_len;
        sent = 0;
        while (sent < 1100) begin
            idling_on = ($urandom_range(0, 3) != 0);
            apply_setting(pick_grid(), pick_grid(), pick_grid(), pick_count());
            phase_len = $urandom_range(10, 60);
            repeat (phase_len) send_request(pick_block_no());
            sent += phase_len;
            settle();
        end
    endtask

    // closing stretch at full rate on both sides
    task automatic test_steady_stream();
        idling_on = 1'b0;
        apply_setting(pick_grid(), pick_grid(), pick_grid(), pick_count());
        repeat (100) send_request(pick_block_no());
        settle();
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_block_number = '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        idling_on      = 1'b0;
        receiver_hold  = 0;
        stall_left     = 0;
        grid_pts       = '{1, 1, 1};
        blocks_cfg     = 1;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        idling_on = 1'b1;
        test_directed_settings();
        test_output_stall();
        test_random_settings();
        test_steady_stream();

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (pending_extents.size() != 0)
            flag_mismatch("results never returned", 0, pending_extents.size());
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/gbe_pkg.sv
hw/rtl/gbe_serial_div.sv
hw/rtl/gbe_serial_mul.sv
hw/rtl/grid_block_extent_calculator_unit.sv
dv/tb_grid_block_extent_calculator_unit.sv
